[hw/rtl/bba_pkg.sv]
// shared types, codes and constants of the bitmap block allocator
`timescale 1ns / 1ps

package bba_pkg;

	localparam int NUM_BLOCKS_DEF  = 4096;
	localparam int MAX_REQUEST_DEF = 64;
	localparam int WORD_W          = 32;
	localparam int OFF_W           = 5;
	localparam int RSV_W           = 13;
	localparam int KIND_W          = 2;
	localparam int COUNT_W         = 7;
	localparam int INDEX_W         = 12;
	localparam int STATUS_W        = 2;

	localparam logic [RSV_W-1:0] RESERVED_RESET = RSV_W'(1);

	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FORMAT = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COUNT_W-1:0] request_count;
		logic [INDEX_W-1:0] block_index;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  granted_block;
		logic                block_valid;
		logic                last;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_FMT_CLR,
		ST_AL_RD,
		ST_AL_LD,
		ST_AL_SCAN,
		ST_AL_WB,
		ST_FR_RD,
		ST_FR_LD,
		ST_FR_WB,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		RESP_OK,
		RESP_RANGE,
		RESP_ALLOC
	} resp_t;

	typedef struct packed {
		logic  accept;
		logic  mem_rd;
		logic  load_alloc;
		logic  load_free;
		logic  take;
		logic  wb;
		logic  sweep_wr;
		logic  sweep_zero;
		logic  addr_inc;
		logic  emit;
		resp_t resp;
	} cmd_t;

	typedef struct packed {
		logic              slot_free;
		logic              has_free;
		logic              cnt_done;
		logic              addr_last;
		logic              pend_valid;
		logic [KIND_W-1:0] req_kind;
		logic              req_zero;
		logic              req_oob;
	} sts_t;

endpackage

[hw/rtl/bba_ctrl.sv]
// sequencer of the bitmap block allocator
`timescale 1ns / 1ps

module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd
);

	bba_pkg::state_t state_q, state_d;
	bba_pkg::resp_t  resp_q, resp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::ST_INIT_CLR;
			resp_q  <= bba_pkg::RESP_OK;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		resp_d   = resp_q;
		cmd      = '0;
		cmd.resp = resp_q;
		in_stall = 1'b1;
		unique case (state_q)
			bba_pkg::ST_INIT_CLR: begin
				cmd.sweep_wr   = 1'b1;
				cmd.sweep_zero = 1'b1;
				cmd.addr_inc   = 1'b1;
				if (sts.addr_last) state_d = bba_pkg::ST_IDLE;
			end
			bba_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					priority if (sts.req_kind == bba_pkg::KIND_ALLOC) begin
						if (sts.req_zero) begin
							resp_d  = bba_pkg::RESP_OK;
							state_d = bba_pkg::ST_RESP;
						end else begin
							state_d = bba_pkg::ST_AL_RD;
						end
					end else if (sts.req_kind == bba_pkg::KIND_FREE) begin
						if (sts.req_oob) begin
							resp_d  = bba_pkg::RESP_RANGE;
							state_d = bba_pkg::ST_RESP;
						end else begin
							state_d = bba_pkg::ST_FR_RD;
						end
					end else if (sts.req_kind == bba_pkg::KIND_FORMAT) begin
						state_d = bba_pkg::ST_FMT_CLR;
					end else begin
						// unused kind: taken and dropped
						state_d = bba_pkg::ST_IDLE;
					end
				end
			end
			bba_pkg::ST_FMT_CLR: begin
				cmd.sweep_wr = 1'b1;
				cmd.addr_inc = 1'b1;
				if (sts.addr_last) begin
					resp_d  = bba_pkg::RESP_OK;
					state_d = bba_pkg::ST_RESP;
				end
			end
			bba_pkg::ST_AL_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = bba_pkg::ST_AL_LD;
			end
			bba_pkg::ST_AL_LD: begin
				cmd.load_alloc = 1'b1;
				state_d        = bba_pkg::ST_AL_SCAN;
			end
			bba_pkg::ST_AL_SCAN: begin
				if (sts.cnt_done || !sts.has_free) begin
					state_d = bba_pkg::ST_AL_WB;
				end else if (!sts.pend_valid || sts.slot_free) begin
					cmd.take = 1'b1;
				end
			end
			bba_pkg::ST_AL_WB: begin
				cmd.wb = 1'b1;
				if (sts.cnt_done || sts.addr_last) begin
					resp_d  = bba_pkg::RESP_ALLOC;
					state_d = bba_pkg::ST_RESP;
				end else begin
					cmd.addr_inc = 1'b1;
					state_d      = bba_pkg::ST_AL_RD;
				end
			end
			bba_pkg::ST_FR_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = bba_pkg::ST_FR_LD;
			end
			bba_pkg::ST_FR_LD: begin
				cmd.load_free = 1'b1;
				state_d       = bba_pkg::ST_FR_WB;
			end
			bba_pkg::ST_FR_WB: begin
				cmd.wb  = 1'b1;
				resp_d  = bba_pkg::RESP_OK;
				state_d = bba_pkg::ST_RESP;
			end
			bba_pkg::ST_RESP: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = bba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/bba_dpath.sv]
// map memory, word scan, request registers and output register
`timescale 1ns / 1ps

module bba_dpath #(
	parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
	parameter int MAX_REQUEST = bba_pkg::MAX_REQUEST_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bba_pkg::RSV_W-1:0]     cfg_wr_data,
	input  bba_pkg::in_item_t             in_data,
	input  logic                          out_stall,
	output logic                          out_valid,
	output bba_pkg::out_item_t            out_data,
	input  bba_pkg::cmd_t                 cmd,
	output bba_pkg::sts_t                 sts
);

	localparam int WORD_W    = bba_pkg::WORD_W;
	localparam int OFF_W     = bba_pkg::OFF_W;
	localparam int WORDS     = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WADDR_W   = $clog2(WORDS);
	localparam int BW        = WADDR_W + OFF_W;
	localparam int NW        = (BW + 1 > bba_pkg::RSV_W) ? BW + 1 : bba_pkg::RSV_W;
	localparam int LAST_BITS = NUM_BLOCKS - WORD_W * (WORDS - 1);
	localparam logic [WORD_W-1:0] ONES      = {WORD_W{1'b1}};
	localparam logic [WORD_W-1:0] MSB       = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] LAST_MASK = ~(ONES >> LAST_BITS);
	localparam logic [WADDR_W-1:0] ADDR_END = WADDR_W'(WORDS - 1);
	localparam logic [NW-1:0] NB = NW'(NUM_BLOCKS);
	localparam logic [bba_pkg::COUNT_W-1:0] CNT_MAX = bba_pkg::COUNT_W'(MAX_REQUEST);

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic [WORD_W-1:0] cur_q;
	logic [WADDR_W-1:0] addr_q;
	logic [bba_pkg::RSV_W-1:0] reserved_q;
	logic [NW-1:0] fmt_n_q;
	logic [OFF_W-1:0] idx_off_q;
	logic [bba_pkg::COUNT_W-1:0] count_q, found_q;
	logic [BW-1:0] pend_blk_q;
	logic pend_valid_q;
	logic out_valid_q;
	bba_pkg::out_item_t out_q;

	logic [WORD_W-1:0] avail, range_mask, fmt_word, wdata;
	logic [OFF_W-1:0] free_off;
	logic [NW-1:0] base, diff, rsv_ext, idx_ext;
	logic [bba_pkg::COUNT_W-1:0] cnt_sat;
	logic slot_free, out_load, mem_we;
	bba_pkg::out_item_t out_next, final_item;

	// request decode on the incoming item
	always_comb begin
		rsv_ext = NW'(reserved_q);
		idx_ext = NW'(in_data.block_index);
		cnt_sat = (in_data.request_count > CNT_MAX) ? CNT_MAX : in_data.request_count;
	end

	// free bits of the held word; bits past the map end count as used
	always_comb begin
		range_mask = (addr_q == ADDR_END) ? LAST_MASK : ONES;
		avail      = ~cur_q & range_mask;
		free_off   = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (avail[WORD_W-1-j]) free_off = OFF_W'(j);
		end
	end

	// format word: leading bits set for blocks below the reserved count
	always_comb begin
		base = NW'({addr_q, {OFF_W{1'b0}}});
		diff = fmt_n_q - base;
		if (fmt_n_q <= base) fmt_word = '0;
		else if (diff >= NW'(WORD_W)) fmt_word = ONES;
		else fmt_word = ~(ONES >> diff[OFF_W-1:0]);
		wdata  = cmd.sweep_wr ? (cmd.sweep_zero ? '0 : fmt_word) : cur_q;
		mem_we = cmd.sweep_wr || cmd.wb;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr_q] <= wdata;
		if (cmd.mem_rd) rdata_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= bba_pkg::RESERVED_RESET;
		end else if (cfg_wr_en) begin
			reserved_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.accept) begin
			addr_q <= (in_data.kind == bba_pkg::KIND_FREE) ?
				WADDR_W'(in_data.block_index >> OFF_W) : '0;
		end else if (cmd.addr_inc) begin
			addr_q <= addr_q + WADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fmt_n_q   <= (rsv_ext > NB) ? NB : rsv_ext;
			idx_off_q <= in_data.block_index[OFF_W-1:0];
			count_q   <= cnt_sat;
			found_q   <= '0;
		end else if (cmd.take) begin
			found_q <= found_q + bba_pkg::COUNT_W'(1);
		end
		if (cmd.load_alloc) cur_q <= rdata_q;
		else if (cmd.load_free) cur_q <= rdata_q & ~(MSB >> idx_off_q);
		else if (cmd.take) cur_q <= cur_q | (MSB >> free_off);
		if (cmd.take) pend_blk_q <= {addr_q, free_off};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.accept) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.take) begin
			pend_valid_q <= 1'b1;
		end
	end

	// closing transfer of a request
	always_comb begin
		final_item      = '0;
		final_item.last = 1'b1;
		unique case (cmd.resp)
			bba_pkg::RESP_OK:    final_item.status = bba_pkg::STATUS_OK;
			bba_pkg::RESP_RANGE: final_item.status = bba_pkg::STATUS_RANGE;
			bba_pkg::RESP_ALLOC: begin
				if (pend_valid_q) begin
					final_item.granted_block = bba_pkg::INDEX_W'(pend_blk_q);
					final_item.block_valid   = 1'b1;
					final_item.status = (found_q == count_q) ?
						bba_pkg::STATUS_OK : bba_pkg::STATUS_SHORT;
				end else begin
					final_item.status = bba_pkg::STATUS_SHORT;
				end
			end
			default: final_item.status = bba_pkg::STATUS_OK;
		endcase
	end

	// a held grant goes out once the next one is found; the closing transfer goes out on emit
	always_comb begin
		slot_free = !out_valid_q || !out_stall;
		out_next  = final_item;
		out_load  = cmd.emit;
		if (cmd.take && pend_valid_q) begin
			out_next               = '0;
			out_next.granted_block = bba_pkg::INDEX_W'(pend_blk_q);
			out_next.block_valid   = 1'b1;
			out_load               = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_next;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts            = '0;
		sts.slot_free  = slot_free;
		sts.has_free   = |avail;
		sts.cnt_done   = (found_q == count_q);
		sts.addr_last  = (addr_q == ADDR_END);
		sts.pend_valid = pend_valid_q;
		sts.req_kind   = in_data.kind;
		sts.req_zero   = (in_data.request_count == '0);
		sts.req_oob    = (idx_ext >= NB);
	end

endmodule

[hw/rtl/bitmap_block_allocator_core.sv]
// top level of the bitmap block allocator
//
//   port group       dir  handshake          payload
//   in_*             in   in_valid/in_stall  in_data: kind, request_count, block_index
//   out_*            out  out_valid/out_stall out_data: granted_block, block_valid, last, status
//   cfg_*            in   cfg_wr_en          cfg_wr_data: reserved_blocks
//
// allocate: each map word is read, loaded, scanned for free blocks and written back,
//   word by word until the request is met or the last word is done, then the result goes out
// free: read, modify, write, result; format: a write pass over every map word, then the result
// after reset a clearing pass over every map word runs with in_stall high
// a stalled output holds the scan; the next request is taken while the last result waits
`timescale 1ns / 1ps

module bitmap_block_allocator_core #(
	parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
	parameter int MAX_REQUEST = bba_pkg::MAX_REQUEST_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [bba_pkg::RSV_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  bba_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output bba_pkg::out_item_t        out_data
);

	bba_pkg::cmd_t cmd;
	bba_pkg::sts_t sts;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bba_dpath #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.MAX_REQUEST (MAX_REQUEST)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

[hw/rtl/bba_checker.sv]
// port-level checks of the bitmap block allocator and their binding
`timescale 1ns / 1ps

module bba_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input bba_pkg::out_item_t        out_data
);

	// every transfer but the closing one carries a granted block
	a_mid_has_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last) |-> out_data.block_valid)
		else $error("non-final transfer without a block");

	a_mid_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last) |-> (out_data.status == bba_pkg::STATUS_OK))
		else $error("non-final transfer with an error status");

	a_no_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.block_valid) |-> (out_data.granted_block == '0))
		else $error("block number on a transfer without a block");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled output changed");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (.*);
